@@ rtl/swm_pkg.sv @@
// shared types, constants and helpers of the window mode filter and scaler
// used by swm_cell, swm_temp and window_mode_filter_scaler; depends on nothing
package swm_pkg;

    localparam int PROD_W     = 40;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam int OUT_W      = 20;

    localparam logic [13:0]      COMP_Q16  = 14'd11796;
    localparam logic [OUT_W-1:0] OUT20_MAX = 20'hFFFFF;

    localparam logic [CFG_ADDR_W-1:0] REG_VOLT_GAIN = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_AMP_GAIN  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SUPPLY_MV = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_CAL_LOW   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_CAL_HIGH  = 3'd4;

    localparam logic [23:0] RST_VOLT_GAIN = 24'd479723;
    localparam logic [23:0] RST_AMP_GAIN  = 24'd65536;
    localparam logic [11:0] RST_SUPPLY_MV = 12'd3300;
    localparam logic [11:0] RST_CAL_LOW   = 12'd1750;
    localparam logic [11:0] RST_CAL_HIGH  = 12'd1330;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COUNT,
        S_SELECT,
        S_MUL,
        S_COMP,
        S_SUB,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        T_IDLE,
        T_SCALE,
        T_PREP,
        T_DIV,
        T_FIN,
        T_DONE
    } t_temp_state;

    typedef struct packed {
        logic load;
        logic clear;
        logic shift;
        logic count_en;
    } t_cell_ctrl;

    function automatic logic [OUT_W-1:0] round_sat(input logic [PROD_W-1:0] x);
        logic [PROD_W:0]    s;
        logic [PROD_W-16:0] r;
        s = {1'b0, x} + (PROD_W+1)'(32768);
        r = s[PROD_W:16];
        if (r > (PROD_W-15)'(OUT20_MAX)) begin
            return OUT20_MAX;
        end
        return r[OUT_W-1:0];
    endfunction

endpackage

@@ rtl/swm_cell.sv @@
// one window cell: a stored sample and its match count, rotating in a ring
// depends on swm_pkg
module swm_cell import swm_pkg::*; #(
    parameter int VAL_W = 12,
    parameter int CNT_W = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctrl       i_ctrl,
    input  logic             i_sel,
    input  logic [VAL_W-1:0] i_load_val,
    input  logic [VAL_W-1:0] i_nb_val,
    input  logic [CNT_W-1:0] i_nb_cnt,
    input  logic [VAL_W-1:0] i_bcast,
    output logic [VAL_W-1:0] o_val,
    output logic [CNT_W-1:0] o_cnt
);

    logic [VAL_W-1:0] r_val;
    logic [CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0;
            r_cnt <= '0;
        end else if (i_ctrl.shift) begin
            r_val <= i_nb_val;
            r_cnt <= i_nb_cnt + CNT_W'(i_ctrl.count_en && (i_nb_val == i_bcast));
        end else begin
            if (i_ctrl.load && i_sel) begin
                r_val <= i_load_val;
            end
            if (i_ctrl.clear) begin
                r_cnt <= '0;
            end
        end
    end

    assign o_val = r_val;
    assign o_cnt = r_cnt;

endmodule

@@ rtl/swm_temp.sv @@
// temperature scaling with an iterative restoring divider, one quotient bit a cycle
// depends on swm_pkg
module swm_temp import swm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [11:0]        i_sample,
    input  logic [11:0]        i_supply,
    input  logic [11:0]        i_cal_low,
    input  logic [11:0]        i_cal_high,
    output logic               o_done,
    output logic signed [15:0] o_temp
);

    t_temp_state r_state, n_state;

    logic [23:0]        r_p1;
    logic [23:0]        r_p2;
    logic signed [24:0] r_den;
    logic signed [38:0] r_num;
    logic [39:0]        r_x;
    logic [24:0]        r_y;
    logic [24:0]        r_rem;
    logic               r_neg;
    logic [5:0]         r_bit;
    logic signed [15:0] r_temp;

    logic [37:0] w_an;
    logic [23:0] w_ad;
    logic [25:0] w_rem_sh;
    logic        w_qbit;
    logic [25:0] w_rem_sub;

    assign w_an      = r_num[38] ? 38'(-r_num) : 38'(r_num);
    assign w_ad      = r_den[24] ? 24'(-r_den) : 24'(r_den);
    assign w_rem_sh  = {r_rem, r_x[39]};
    assign w_qbit    = (w_rem_sh >= {1'b0, r_y});
    assign w_rem_sub = w_rem_sh - {1'b0, r_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            T_IDLE, T_DONE: begin
                if (i_start) n_state = T_SCALE;
            end
            T_SCALE: n_state = T_PREP;
            T_PREP: begin
                n_state = (r_den == '0) ? T_DONE : T_DIV;
            end
            T_DIV: begin
                if (r_bit == '0) n_state = T_FIN;
            end
            T_FIN:   n_state = T_DONE;
            default: n_state = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            T_IDLE, T_DONE: begin
                if (i_start) begin
                    r_p1  <= 24'(i_sample) * 24'(i_supply);
                    r_p2  <= 24'(i_cal_low) * 24'd3300;
                    r_den <= 25'($signed({1'b0, i_cal_high}) - $signed({1'b0, i_cal_low}))
                             * 25'sd3300;
                end
            end
            T_SCALE: begin
                r_num <= 39'($signed({1'b0, r_p1}) - $signed({1'b0, r_p2})) * 39'sd8000;
            end
            T_PREP: begin
                if (r_den == '0) begin
                    if (r_num > 0) begin
                        r_temp <= 16'sh7FFF;
                    end else if (r_num < 0) begin
                        r_temp <= 16'sh8000;
                    end else begin
                        r_temp <= 16'sd3000;
                    end
                end
                r_x   <= {1'b0, w_an, 1'b0} + 40'(w_ad);
                r_y   <= {w_ad, 1'b0};
                r_neg <= r_num[38] != r_den[24];
                r_rem <= '0;
                r_bit <= 6'd39;
            end
            T_DIV: begin
                r_rem <= w_qbit ? w_rem_sub[24:0] : w_rem_sh[24:0];
                r_x   <= {r_x[38:0], w_qbit};
                r_bit <= r_bit - 6'd1;
            end
            T_FIN: begin
                if (!r_neg) begin
                    r_temp <= (r_x > 40'd29767) ? 16'sh7FFF
                                                : $signed(r_x[15:0] + 16'd3000);
                end else begin
                    r_temp <= (r_x > 40'd35768) ? 16'sh8000
                                                : $signed(16'd3000 - r_x[15:0]);
                end
            end
            default: ;
        endcase
    end

    assign o_done = (r_state == T_DONE);
    assign o_temp = r_temp;

endmodule

@@ rtl/window_mode_filter_scaler.sv @@
// top level: ring of window cells, mode selection, gain scaling and temperature unit
// depends on swm_pkg, swm_cell and swm_temp
//
// channel   dir  handshake                         payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready   volt, amp, temp samples
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready   mv, ma, temp, both modes
// cfg       in   i_cfg_we                          register index and data
//
// for each beat the cell ring rotates once to count matches and once to pick the mode,
// then three scaling steps (multiply, compensation, subtraction); the temperature divider
// runs alongside, and at small depths the result waits in S_DONE until the divider is done.
// reset clears the windows, write position and registers to their defaults.
// a new beat is taken once the previous one has reached the output register.
module window_mode_filter_scaler import swm_pkg::*; #(
    parameter int WINDOW_DEPTH = 45,
    parameter int SAMPLE_BITS  = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // volt_sample[11:0], amp_sample[23:12], temp_sample[35:24], zero pad
    input  logic [39:0]           i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // out_millivolts[19:0], out_milliamps[39:20], temp_centideg[55:40],
    // volt_mode[67:56], amp_mode[79:68]
    output logic [79:0]           o_m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int POS_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

    t_state r_state, n_state;

    logic [23:0] r_volt_gain;
    logic [23:0] r_amp_gain;
    logic [11:0] r_supply_mv;
    logic [11:0] r_cal_low;
    logic [11:0] r_cal_high;

    logic [POS_W-1:0]       r_wpos;
    logic [POS_W-1:0]       r_k;
    logic [SAMPLE_BITS-1:0] r_best_v, r_best_a;
    logic [CNT_W-1:0]       r_best_vc, r_best_ac;
    logic [PROD_W-1:0]      r_i16, r_v16, r_c16;
    logic [OUT_W-1:0]       r_ma, r_mv;
    logic                   r_out_valid;
    logic [79:0]            r_out_data;

    logic                   w_accept;
    logic                   w_out_free;
    logic                   w_temp_done;
    logic signed [15:0]     w_temp;
    t_cell_ctrl             w_ctrl;
    logic [PROD_W+13:0]     w_cprod;

    logic [SAMPLE_BITS-1:0] w_vval [WINDOW_DEPTH];
    logic [SAMPLE_BITS-1:0] w_aval [WINDOW_DEPTH];
    logic [CNT_W-1:0]       w_vcnt [WINDOW_DEPTH];
    logic [CNT_W-1:0]       w_acnt [WINDOW_DEPTH];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;

    assign w_ctrl.load     = w_accept;
    assign w_ctrl.clear    = w_accept;
    assign w_ctrl.shift    = (r_state == S_COUNT) || (r_state == S_SELECT);
    assign w_ctrl.count_en = (r_state == S_COUNT);

    assign w_cprod = (PROD_W+14)'(r_i16) * (PROD_W+14)'(COMP_Q16);

    for (genvar p = 0; p < WINDOW_DEPTH; p++) begin : g_cell
        localparam int NB = (p == WINDOW_DEPTH - 1) ? 0 : p + 1;
        logic w_sel;
        assign w_sel = (r_wpos == POS_W'(p));

        swm_cell #(.VAL_W(SAMPLE_BITS), .CNT_W(CNT_W)) u_vcell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_ctrl),
            .i_sel      (w_sel),
            .i_load_val (SAMPLE_BITS'(i_s_axis_tdata[11:0])),
            .i_nb_val   (w_vval[NB]),
            .i_nb_cnt   (w_vcnt[NB]),
            .i_bcast    (w_vval[0]),
            .o_val      (w_vval[p]),
            .o_cnt      (w_vcnt[p])
        );

        swm_cell #(.VAL_W(SAMPLE_BITS), .CNT_W(CNT_W)) u_acell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_ctrl),
            .i_sel      (w_sel),
            .i_load_val (SAMPLE_BITS'(i_s_axis_tdata[23:12])),
            .i_nb_val   (w_aval[NB]),
            .i_nb_cnt   (w_acnt[NB]),
            .i_bcast    (w_aval[0]),
            .o_val      (w_aval[p]),
            .o_cnt      (w_acnt[p])
        );
    end

    swm_temp u_temp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_sample   (i_s_axis_tdata[35:24]),
        .i_supply   (r_supply_mv),
        .i_cal_low  (r_cal_low),
        .i_cal_high (r_cal_high),
        .o_done     (w_temp_done),
        .o_temp     (w_temp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volt_gain <= RST_VOLT_GAIN;
            r_amp_gain  <= RST_AMP_GAIN;
            r_supply_mv <= RST_SUPPLY_MV;
            r_cal_low   <= RST_CAL_LOW;
            r_cal_high  <= RST_CAL_HIGH;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_VOLT_GAIN: r_volt_gain <= i_cfg_wdata;
                REG_AMP_GAIN:  r_amp_gain  <= i_cfg_wdata;
                REG_SUPPLY_MV: r_supply_mv <= i_cfg_wdata[11:0];
                REG_CAL_LOW:   r_cal_low   <= i_cfg_wdata[11:0];
                REG_CAL_HIGH:  r_cal_high  <= i_cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wpos      <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_wpos <= (r_wpos == POS_W'(WINDOW_DEPTH - 1)) ? '0 : r_wpos + POS_W'(1);
            end
            if (w_ctrl.shift) begin
                r_k <= (r_k == POS_W'(WINDOW_DEPTH - 1)) ? '0 : r_k + POS_W'(1);
            end
            if (r_state == S_DONE && n_state == S_IDLE) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_COUNT;
            end
            S_COUNT: begin
                if (r_k == POS_W'(WINDOW_DEPTH - 1)) n_state = S_SELECT;
            end
            S_SELECT: begin
                if (r_k == POS_W'(WINDOW_DEPTH - 1)) n_state = S_MUL;
            end
            S_MUL:  n_state = S_COMP;
            S_COMP: n_state = S_SUB;
            S_SUB:  n_state = S_DONE;
            S_DONE: begin
                if (w_temp_done && w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_best_vc <= '0;
                r_best_ac <= '0;
            end
            S_SELECT: begin
                if (w_vcnt[0] > r_best_vc) begin
                    r_best_vc <= w_vcnt[0];
                    r_best_v  <= w_vval[0];
                end
                if (w_acnt[0] > r_best_ac) begin
                    r_best_ac <= w_acnt[0];
                    r_best_a  <= w_aval[0];
                end
            end
            S_MUL: begin
                r_i16 <= PROD_W'(r_best_a) * PROD_W'(r_amp_gain);
                r_v16 <= PROD_W'(r_best_v) * PROD_W'(r_volt_gain);
            end
            S_COMP: begin
                r_c16 <= PROD_W'(w_cprod >> 16);
                r_ma  <= round_sat(r_i16);
            end
            S_SUB: begin
                r_mv <= (r_v16 <= r_c16) ? '0 : round_sat(r_v16 - r_c16);
            end
            S_DONE: begin
                if (n_state == S_IDLE) begin
                    r_out_data <= {12'(r_best_a), 12'(r_best_v), w_temp, r_ma, r_mv};
                end
            end
            default: ;
        endcase
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == S_COUNT)
        else $error("accepted beat did not start the count pass");

    a_select_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SELECT && r_k == POS_W'(WINDOW_DEPTH - 1)) |=> r_state == S_MUL)
        else $error("select pass did not end after one ring rotation");

    a_wpos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wpos <= POS_W'(WINDOW_DEPTH - 1))
        else $error("write position beyond window");

    a_result_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && n_state == S_IDLE) |=> o_m_axis_tvalid)
        else $error("finished beat not presented");

endmodule

@@ tb/sv/tb_top.sv @@
// self-checking testbench of window_mode_filter_scaler: sample beats in, scaled results out
// holds its own window mode filter and scaler predictor; depends on swm_pkg and the rtl
module tb_top import swm_pkg::*; ();

    localparam int DEPTH = 45;

    typedef struct packed {
        logic [11:0] amp_mode;
        logic [11:0] volt_mode;
        logic [15:0] temp_centideg;
        logic [19:0] out_milliamps;
        logic [19:0] out_millivolts;
    } t_reading;

    class reading_board;
        logic [11:0] volt_win[DEPTH];
        logic [11:0] amp_win[DEPTH];
        int unsigned wpos;
        logic [23:0] volt_gain, amp_gain;
        logic [11:0] supply_mv, cal_low, cal_high;
        t_reading pending[$];
        int unsigned n_checked, n_errors;

        function void clear();
            for (int i = 0; i < DEPTH; i++) begin
                volt_win[i] = '0;
                amp_win[i] = '0;
            end
            wpos = 0;
            volt_gain = RST_VOLT_GAIN;
            amp_gain = RST_AMP_GAIN;
            supply_mv = RST_SUPPLY_MV;
            cal_low = RST_CAL_LOW;
            cal_high = RST_CAL_HIGH;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_VOLT_GAIN: volt_gain = val;
                REG_AMP_GAIN: amp_gain = val;
                REG_SUPPLY_MV: supply_mv = val[11:0];
                REG_CAL_LOW: cal_low = val[11:0];
                REG_CAL_HIGH: cal_high = val[11:0];
                default: ;
            endcase
        endfunction

        function logic [11:0] most_common(logic [11:0] w[DEPTH]);
            int best_cnt, cnt;
            logic [11:0] best;
            best_cnt = 0;
            best = w[0];
            for (int i = 0; i < DEPTH; i++) begin
                cnt = 1;
                for (int j = i + 1; j < DEPTH; j++) if (w[j] == w[i]) cnt++;
                if (cnt > best_cnt) begin
                    best_cnt = cnt;
                    best = w[i];
                end
            end
            return best;
        endfunction

        function logic [19:0] round20(longint unsigned x);
            longint unsigned r;
            r = (x + 32768) >> 16;
            return (r > 64'd1048575) ? 20'hFFFFF : r[19:0];
        endfunction

        function logic [15:0] centideg(logic [11:0] t);
            longint n, d, q;
            longint unsigned an, ad;
            n = (longint'(t) * longint'(supply_mv) - longint'(cal_low) * 3300) * 8000;
            d = (longint'(cal_high) - longint'(cal_low)) * 3300;
            if (d == 0) begin
                q = (n > 0) ? 32767 : (n < 0) ? -32768 : 3000;
            end else begin
                an = (n < 0) ? -n : n;
                ad = (d < 0) ? -d : d;
                q = longint'((2 * an + ad) / (2 * ad));
                if ((n < 0) != (d < 0)) q = -q;
                q += 3000;
                if (q > 32767) q = 32767;
                if (q < -32768) q = -32768;
            end
            return q[15:0];
        endfunction

        function void note_samples(logic [11:0] vs, logic [11:0] as, logic [11:0] ts);
            t_reading r;
            longint unsigned i16, v16, c16;
            volt_win[wpos] = vs;
            amp_win[wpos] = as;
            wpos = (wpos + 1) % DEPTH;
            r.volt_mode = most_common(volt_win);
            r.amp_mode = most_common(amp_win);
            i16 = longint'(r.amp_mode) * amp_gain;
            v16 = longint'(r.volt_mode) * volt_gain;
            c16 = (i16 * 11796) >> 16;
            r.out_millivolts = (v16 <= c16) ? 20'd0 : round20(v16 - c16);
            r.out_milliamps = round20(i16);
            r.temp_centideg = centideg(ts);
            pending.push_back(r);
        endfunction

        function void check_reading(t_reading got);
            t_reading exp;
            if (pending.size() == 0) begin
                $error("unexpected result beat %h", got);
                n_errors++;
                return;
            end
            exp = pending.pop_front();
            n_checked++;
            if (got.out_millivolts !== exp.out_millivolts) begin
                $error("out_millivolts exp %0d got %0d", exp.out_millivolts, got.out_millivolts);
                n_errors++;
            end
            if (got.out_milliamps !== exp.out_milliamps) begin
                $error("out_milliamps exp %0d got %0d", exp.out_milliamps, got.out_milliamps);
                n_errors++;
            end
            if (got.temp_centideg !== exp.temp_centideg) begin
                $error("temp_centideg exp %0d got %0d", $signed(exp.temp_centideg),
                       $signed(got.temp_centideg));
                n_errors++;
            end
            if (got.volt_mode !== exp.volt_mode) begin
                $error("volt_mode exp %0d got %0d", exp.volt_mode, got.volt_mode);
                n_errors++;
            end
            if (got.amp_mode !== exp.amp_mode) begin
                $error("amp_mode exp %0d got %0d", exp.amp_mode, got.amp_mode);
                n_errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [39:0] s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [79:0] m_data;
    logic cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int send_idle_pct = 0;
    int stall_pct = 0;
    bit hold_off = 1'b0;
    int n_beats = 0;
    int n_cfg = 0;

    reading_board board = new();

    always #1 i_clk = ~i_clk;

    window_mode_filter_scaler DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready), .i_s_axis_tdata(s_data),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready), .o_m_axis_tdata(m_data),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_wdata(cfg_wdata)
    );

    // result side: random stall, checked on accepted beats
    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready) board.check_reading(m_data);
        m_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end

    task automatic send_samples(logic [11:0] vs, logic [11:0] as, logic [11:0] ts);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= {4'b0, ts, as, vs};
        do @(posedge i_clk); while (!s_ready);
        board.note_samples(vs, as, ts);
        n_beats++;
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        board.set_reg(idx, val);
        n_cfg++;
        @(posedge i_clk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // mostly values from a small pool so the modes move and ties occur
    task automatic send_random(int count);
        logic [11:0] pool[4];
        for (int i = 0; i < 4; i++) pool[i] = 12'($urandom_range(4095));
        for (int i = 0; i < count; i++) begin
            send_samples(($urandom_range(3) != 0) ? pool[$urandom_range(3)]
                                                  : 12'($urandom_range(4095)),
                         ($urandom_range(3) != 0) ? pool[$urandom_range(3)]
                                                  : 12'($urandom_range(4095)),
                         12'($urandom_range(4095)));
        end
    endtask

    task automatic random_regs(bit extreme);
        write_reg(REG_VOLT_GAIN, extreme ? 24'hFFFFFF
                                         : CFG_DATA_W'($urandom_range(24'hFFFFFF)));
        write_reg(REG_AMP_GAIN, extreme ? 24'hFFFFFF
                                        : CFG_DATA_W'($urandom_range(24'hFFFFFF)));
        write_reg(REG_SUPPLY_MV, extreme ? 24'd3600
                                         : CFG_DATA_W'($urandom_range(3600, 2000)));
        write_reg(REG_CAL_LOW, CFG_DATA_W'($urandom_range(4095)));
        write_reg(REG_CAL_HIGH, CFG_DATA_W'($urandom_range(4095)));
    endtask

    initial begin
        board.clear();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, ties, zero span, negative compensation
        send_samples(12'd0, 12'd0, 12'd0);
        send_samples(12'hFFF, 12'hFFF, 12'hFFF);
        send_samples(12'hAAA, 12'h555, 12'h555);
        send_samples(12'h555, 12'hAAA, 12'hAAA);
        for (int i = 0; i < 6; i++) send_samples(12'd7, 12'hFFF, 12'd1750);
        drain();
        write_reg(REG_VOLT_GAIN, 24'd0);
        write_reg(REG_AMP_GAIN, 24'hFFFFFF);
        write_reg(REG_CAL_HIGH, 24'd1750);
        write_reg(REG_SUPPLY_MV, 24'd3300);
        write_reg(3'd7, 24'h123456);
        send_samples(12'd1, 12'hFFF, 12'd1750);
        send_samples(12'd1, 12'hFFF, 12'd0);
        send_samples(12'd1, 12'hFFF, 12'hFFF);
        drain();
        write_reg(REG_CAL_LOW, 24'd0);
        write_reg(REG_CAL_HIGH, 24'd4095);
        write_reg(REG_SUPPLY_MV, 24'd2000);
        write_reg(REG_VOLT_GAIN, 24'hFFFFFF);
        write_reg(REG_AMP_GAIN, 24'd0);
        send_samples(12'hFFF, 12'd0, 12'd0);
        send_samples(12'hFFF, 12'd0, 12'hFFF);
        drain();
        write_reg(REG_CAL_LOW, 24'd4095);
        write_reg(REG_CAL_HIGH, 24'd0);
        send_samples(12'd0, 12'd0, 12'd0);
        send_samples(12'd0, 12'd0, 12'hFFF);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0; stall_pct = 0; end
                1: begin send_idle_pct = 81; stall_pct = 0; end
                2: begin send_idle_pct = 0; stall_pct = 81; end
                default: begin send_idle_pct = 37; stall_pct = 37; end
            endcase
            if (ph == 0) random_regs(1'b1);
            else if (ph != 4) random_regs(1'b0);
            if (ph == 4) begin
                // back to defaults by writing them
                write_reg(REG_VOLT_GAIN, RST_VOLT_GAIN);
                write_reg(REG_AMP_GAIN, RST_AMP_GAIN);
                write_reg(REG_SUPPLY_MV, CFG_DATA_W'(RST_SUPPLY_MV));
                write_reg(REG_CAL_LOW, CFG_DATA_W'(RST_CAL_LOW));
                write_reg(REG_CAL_HIGH, CFG_DATA_W'(RST_CAL_HIGH));
            end
            if (ph == 2) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (800) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                    send_random(240);
                join
            end else begin
                send_random(240);
            end
            drain();
        end

        $display("covered %0d sample beats, %0d register writes, %0d results checked",
                 n_beats, n_cfg, board.n_checked);
        if (board.n_errors == 0 && board.pending.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
